FILE: rtl/pse_pkg.sv
// Shared types and constants for the postfix stack evaluator.
// Used by pse_alu, postfix_stack_evaluator and pse_checker; depends on nothing.
`default_nettype none

package pse_pkg;

  localparam int unsigned WORD_W  = 32;
  localparam int unsigned SYM_W   = 8;
  localparam int unsigned DEPTH_W = 5;
  localparam int unsigned STAT_W  = 3;
  localparam int unsigned DIV_STEPS = 32;

  // Status codes carried in the result beat.
  localparam logic [STAT_W-1:0] ST_OK    = 3'd0;
  localparam logic [STAT_W-1:0] ST_UNDER = 3'd1;
  localparam logic [STAT_W-1:0] ST_OVER  = 3'd2;
  localparam logic [STAT_W-1:0] ST_DIVZ  = 3'd3;
  localparam logic [STAT_W-1:0] ST_UNSUP = 3'd4;

  // Characters that the decoder recognizes.
  localparam logic [SYM_W-1:0] CH_PLUS  = 8'h2B;
  localparam logic [SYM_W-1:0] CH_MINUS = 8'h2D;
  localparam logic [SYM_W-1:0] CH_STAR  = 8'h2A;
  localparam logic [SYM_W-1:0] CH_SLASH = 8'h2F;
  localparam logic [SYM_W-1:0] CH_CARET = 8'h5E;
  localparam logic [SYM_W-1:0] CH_LPAR  = 8'h28;
  localparam logic [SYM_W-1:0] CH_RPAR  = 8'h29;
  localparam logic [SYM_W-1:0] CH_ZERO  = 8'h30;

  typedef struct packed {
    logic [SYM_W-1:0] symbol;
    logic             end_of_expr;
  } in_t;

  typedef struct packed {
    logic signed [WORD_W-1:0] top_value;
    logic [DEPTH_W-1:0]       depth;
    logic [STAT_W-1:0]        status;
    logic                     done_res;
  } out_t;

  typedef enum logic [1:0] {
    ALU_ADD,
    ALU_SUB,
    ALU_MUL,
    ALU_DIV
  } alu_op_t;

  typedef struct packed {
    logic    start;
    alu_op_t op;
  } alu_req_t;

  typedef enum logic [1:0] {
    S_IDLE,
    S_EXEC,
    S_WAIT,
    S_DONE
  } state_t;

  function automatic logic is_unsup(input logic [SYM_W-1:0] sym);
    return (sym == CH_CARET) || (sym == CH_LPAR) || (sym == CH_RPAR);
  endfunction

  function automatic logic is_arith(input logic [SYM_W-1:0] sym);
    return (sym == CH_PLUS) || (sym == CH_MINUS) || (sym == CH_STAR) || (sym == CH_SLASH);
  endfunction

  function automatic alu_op_t op_of(input logic [SYM_W-1:0] sym);
    alu_op_t op;
    case (sym)
      CH_PLUS:  op = ALU_ADD;
      CH_MINUS: op = ALU_SUB;
      CH_STAR:  op = ALU_MUL;
      default:  op = ALU_DIV;
    endcase
    return op;
  endfunction

endpackage

`default_nettype wire

FILE: rtl/pse_alu.sv
// Shared arithmetic unit: add, subtract and multiply into a registered result, signed divide bit-serially.
// Depends on pse_pkg.
`default_nettype none

module pse_alu (
  input  wire logic                       clk,
  input  wire logic                       rst_n,
  input  wire pse_pkg::alu_req_t          req,
  input  wire logic [pse_pkg::WORD_W-1:0] lhs,
  input  wire logic [pse_pkg::WORD_W-1:0] rhs,
  output logic                            done,
  output logic [pse_pkg::WORD_W-1:0]      result
);

  localparam int unsigned W = pse_pkg::WORD_W;
  localparam int unsigned STEP_W = $clog2(pse_pkg::DIV_STEPS);

  logic              div_busy_r, div_busy_nxt;
  logic              fix_r, fix_nxt;
  logic              done_r, done_nxt;
  logic [STEP_W-1:0] step_r, step_nxt;
  logic [W-1:0]      rem_r, rem_nxt;
  logic [W-1:0]      quo_r, quo_nxt;
  logic [W-1:0]      den_r, den_nxt;
  logic              neg_r, neg_nxt;
  logic [W-1:0]      res_r, res_nxt;

  logic [2*W-1:0]    product;
  logic [W+1:0]      trial;

  assign product = lhs * rhs;
  // Shift one dividend bit into the partial remainder and try to subtract the divisor.
  assign trial = {1'b0, rem_r, quo_r[W-1]} - {2'b00, den_r};

  always_comb begin
    div_busy_nxt = div_busy_r;
    fix_nxt      = 1'b0;
    done_nxt     = 1'b0;
    step_nxt     = step_r;
    rem_nxt      = rem_r;
    quo_nxt      = quo_r;
    den_nxt      = den_r;
    neg_nxt      = neg_r;
    res_nxt      = res_r;
    if (req.start) begin
      case (req.op)
        pse_pkg::ALU_ADD: begin
          res_nxt  = lhs + rhs;
          done_nxt = 1'b1;
        end
        pse_pkg::ALU_SUB: begin
          res_nxt  = lhs - rhs;
          done_nxt = 1'b1;
        end
        pse_pkg::ALU_MUL: begin
          res_nxt  = product[W-1:0];
          done_nxt = 1'b1;
        end
        pse_pkg::ALU_DIV: begin
          div_busy_nxt = 1'b1;
          step_nxt     = '0;
          rem_nxt      = '0;
          quo_nxt      = lhs[W-1] ? (W'(0) - lhs) : lhs;
          den_nxt      = rhs[W-1] ? (W'(0) - rhs) : rhs;
          neg_nxt      = lhs[W-1] ^ rhs[W-1];
        end
        default: begin
          done_nxt = 1'b1;
        end
      endcase
    end else if (div_busy_r) begin
      if (!trial[W+1]) begin
        rem_nxt = trial[W-1:0];
        quo_nxt = {quo_r[W-2:0], 1'b1};
      end else begin
        rem_nxt = {rem_r[W-2:0], quo_r[W-1]};
        quo_nxt = {quo_r[W-2:0], 1'b0};
      end
      step_nxt = step_r + STEP_W'(1);
      if (step_r == STEP_W'(pse_pkg::DIV_STEPS - 1)) begin
        div_busy_nxt = 1'b0;
        fix_nxt      = 1'b1;
      end
    end else if (fix_r) begin
      res_nxt  = neg_r ? (W'(0) - quo_r) : quo_r;
      done_nxt = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      div_busy_r <= 1'b0;
      fix_r      <= 1'b0;
      done_r     <= 1'b0;
    end else begin
      div_busy_r <= div_busy_nxt;
      fix_r      <= fix_nxt;
      done_r     <= done_nxt;
    end
    step_r <= step_nxt;
    rem_r  <= rem_nxt;
    quo_r  <= quo_nxt;
    den_r  <= den_nxt;
    neg_r  <= neg_nxt;
    res_r  <= res_nxt;
  end

  assign done   = done_r;
  assign result = res_r;

endmodule

`default_nettype wire

FILE: rtl/postfix_stack_evaluator.sv
// Top level of the postfix stack evaluator: sequencer, value stack memory and result register.
// Depends on pse_pkg and pse_alu.
//
//   Channel   Direction  Handshake              Payload
//   in_       input      in_valid / in_ready    pse_pkg::in_t  (symbol, end_of_expr)
//   out_      output     out_valid / out_ready  pse_pkg::out_t (top_value, depth, status, done_res)
//
// A beat is taken only in S_IDLE and ends in S_DONE: an operand, underflow, overflow or
// unsupported operator goes there directly, divide by zero through S_EXEC, and an operation
// through S_EXEC and S_WAIT; pse_alu's bit-serial divider retires one quotient bit per cycle.
// Reset is synchronous on rst_n and empties the stack; only entries below the count are used.
// A stalled result waits in the output register while the next beat is taken, and the
// sequencer holds its own result until that register is free.
`default_nettype none

module postfix_stack_evaluator #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           in_valid,
  output logic                in_ready,
  input  wire pse_pkg::in_t   in_data,
  output logic                out_valid,
  input  wire logic           out_ready,
  output pse_pkg::out_t       out_data
);

  localparam int unsigned W  = pse_pkg::WORD_W;
  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  // Sequencer and stack bookkeeping.
  pse_pkg::state_t         state_r, state_nxt;
  logic [CW-1:0]           cnt_r, cnt_nxt;
  logic [W-1:0]            top_r, top_nxt;
  logic [pse_pkg::STAT_W-1:0] status_r, status_nxt;
  logic                    last_r, last_nxt;
  pse_pkg::alu_op_t        op_r, op_nxt;
  logic                    out_valid_r, out_valid_nxt;
  pse_pkg::out_t           out_data_r, out_data_nxt;

  // Stack memory. The top of stack is mirrored in top_r, so only the entry below it is read.
  logic [W-1:0]  stack_mem [STACK_DEPTH];
  logic          mem_we;
  logic [AW-1:0] mem_waddr;
  logic [W-1:0]  mem_wdata;
  logic [AW-1:0] mem_raddr;
  logic [W-1:0]  mem_rdata_r;

  pse_pkg::alu_req_t alu_req;
  logic              alu_done;
  logic [W-1:0]      alu_result;

  logic          accept;
  logic          sym_unsup;
  logic          sym_arith;
  logic          out_load;
  logic [W-1:0]  push_val;

  assign accept    = in_valid && in_ready;
  assign sym_unsup = pse_pkg::is_unsup(in_data.symbol);
  assign sym_arith = pse_pkg::is_arith(in_data.symbol);
  assign out_load  = !out_valid_r || out_ready;
  // The operand value is the character code minus the code of '0', wrapped to 32 bits.
  assign push_val  = W'(in_data.symbol) - W'(pse_pkg::CH_ZERO);
  // Left operand sits one below the top; the read is issued while the beat is accepted.
  assign mem_raddr = AW'(cnt_r - CW'(2));

  pse_alu u_alu (
    .clk    (clk),
    .rst_n  (rst_n),
    .req    (alu_req),
    .lhs    (mem_rdata_r),
    .rhs    (top_r),
    .done   (alu_done),
    .result (alu_result)
  );

  // Next-state logic.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      pse_pkg::S_IDLE: begin
        if (accept) begin
          if (!sym_unsup && sym_arith && (cnt_r >= CW'(2))) begin
            state_nxt = pse_pkg::S_EXEC;
          end else begin
            state_nxt = pse_pkg::S_DONE;
          end
        end
      end
      pse_pkg::S_EXEC: begin
        if ((op_r == pse_pkg::ALU_DIV) && (top_r == '0)) begin
          state_nxt = pse_pkg::S_DONE;
        end else begin
          state_nxt = pse_pkg::S_WAIT;
        end
      end
      pse_pkg::S_WAIT: begin
        if (alu_done) begin
          state_nxt = pse_pkg::S_DONE;
        end
      end
      pse_pkg::S_DONE: begin
        if (out_load) begin
          state_nxt = pse_pkg::S_IDLE;
        end
      end
      default: begin
        state_nxt = pse_pkg::S_IDLE;
      end
    endcase
  end

  // Datapath and output logic.
  always_comb begin
    cnt_nxt       = cnt_r;
    top_nxt       = top_r;
    status_nxt    = status_r;
    last_nxt      = last_r;
    op_nxt        = op_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && !out_ready;
    mem_we        = 1'b0;
    mem_waddr     = AW'(cnt_r);
    mem_wdata     = push_val;
    alu_req.start = 1'b0;
    alu_req.op    = op_r;
    in_ready      = 1'b0;
    case (state_r)
      pse_pkg::S_IDLE: begin
        in_ready = 1'b1;
        if (accept) begin
          last_nxt = in_data.end_of_expr;
          op_nxt   = pse_pkg::op_of(in_data.symbol);
          if (sym_unsup) begin
            status_nxt = pse_pkg::ST_UNSUP;
          end else if (sym_arith) begin
            status_nxt = (cnt_r < CW'(2)) ? pse_pkg::ST_UNDER : pse_pkg::ST_OK;
          end else if (cnt_r == CW'(STACK_DEPTH)) begin
            status_nxt = pse_pkg::ST_OVER;
          end else begin
            status_nxt = pse_pkg::ST_OK;
            mem_we     = 1'b1;
            top_nxt    = push_val;
            cnt_nxt    = cnt_r + CW'(1);
          end
        end
      end
      pse_pkg::S_EXEC: begin
        if ((op_r == pse_pkg::ALU_DIV) && (top_r == '0)) begin
          status_nxt = pse_pkg::ST_DIVZ;
        end else begin
          alu_req.start = 1'b1;
        end
      end
      pse_pkg::S_WAIT: begin
        if (alu_done) begin
          // Two operands collapse into one: the result lands where the left operand was.
          mem_we    = 1'b1;
          mem_waddr = mem_raddr;
          mem_wdata = alu_result;
          top_nxt   = alu_result;
          cnt_nxt   = cnt_r - CW'(1);
        end
      end
      pse_pkg::S_DONE: begin
        if (out_load) begin
          out_valid_nxt          = 1'b1;
          out_data_nxt.top_value = (cnt_r != '0) ? top_r : '0;
          out_data_nxt.depth     = pse_pkg::DEPTH_W'(cnt_r);
          out_data_nxt.status    = status_r;
          out_data_nxt.done_res  = last_r;
          // The end of an expression empties the stack once its result is loaded into the output register.
          if (last_r) begin
            cnt_nxt = '0;
          end
        end
      end
      default: begin
        in_ready = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= pse_pkg::S_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
    top_r      <= top_nxt;
    status_r   <= status_nxt;
    last_r     <= last_nxt;
    op_r       <= op_nxt;
    out_data_r <= out_data_nxt;
  end

  always_ff @(posedge clk) begin
    if (mem_we) begin
      stack_mem[mem_waddr] <= mem_wdata;
    end
    mem_rdata_r <= stack_mem[mem_raddr];
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

FILE: rtl/pse_checker.sv
// Port-level checks for the postfix stack evaluator, bound to the top level.
// Depends on pse_pkg and postfix_stack_evaluator.
`default_nettype none

module pse_checker #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input wire logic          clk,
  input wire logic          rst_n,
  input wire logic          in_valid,
  input wire logic          in_ready,
  input wire logic          out_valid,
  input wire logic          out_ready,
  input wire pse_pkg::out_t out_data
);

  localparam logic SMALL = (STACK_DEPTH < 32);

  // An accepted beat takes the sequencer out of idle, so in_ready is low in the cycle after it.
  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (in_valid && in_ready) |=> !in_ready)
    else $error("in_ready stayed high right after an accepted beat");

  // A result beat holds until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_ready) |=> (out_valid && $stable(out_data)))
    else $error("result beat changed or dropped while stalled");

  // The reported depth never exceeds the stack size.
  a_depth_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && SMALL) |-> (out_data.depth <= pse_pkg::DEPTH_W'(STACK_DEPTH)))
    else $error("reported depth above stack size");

  // An empty stack reports a zero top value.
  a_empty_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && SMALL && (out_data.depth == '0)) |-> (out_data.top_value == '0))
    else $error("empty stack reported a nonzero top value");

  // A result with no beat ever accepted cannot appear straight after reset.
  a_no_early_result: assert property (@(posedge clk) disable iff (!rst_n)
    ($rose(rst_n)) |-> !out_valid)
    else $error("result beat visible right after reset");

endmodule

bind postfix_stack_evaluator pse_checker #(
  .STACK_DEPTH (STACK_DEPTH)
) u_pse_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .in_valid  (in_valid),
  .in_ready  (in_ready),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire

FILE: test/postfix_stack_evaluator_tb.sv
// Self-checking testbench for postfix_stack_evaluator: drives expression characters,
// predicts each stack report with a shadow stack and compares every result beat.
// Depends on pse_pkg and the evaluator RTL only.
module postfix_stack_evaluator_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned STACK_DEPTH = 16;
  // Slowest legal run: ~1300 beats, each up to a divide plus a send gap and a
  // result stall. The limit is several times that.
  localparam int unsigned CYCLE_LIMIT = 1_000_000;

  typedef enum logic [1:0] {
    SYM_OPERAND,
    SYM_ARITH,
    SYM_UNSUP
  } sym_class_t;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_valid = 1'b0;
  logic in_ready;
  pse_pkg::in_t in_data = '0;
  logic out_valid;
  logic out_ready = 1'b0;
  pse_pkg::out_t out_data;

  // Shadow copy of the evaluator's stack, advanced once per accepted input beat.
  logic [pse_pkg::WORD_W-1:0] shadow_stack [STACK_DEPTH];
  int unsigned shadow_fill = 0;

  // Stack reports predicted but not yet seen on the result channel, oldest first.
  pse_pkg::out_t stack_reports_due[$];

  int unsigned beats_sent = 0;
  int unsigned mismatch_count = 0;
  int unsigned cycle_count = 0;
  int unsigned stall_left = 0;
  bit idle_on = 1'b1;

  postfix_stack_evaluator #(
    .STACK_DEPTH(STACK_DEPTH)
  ) u_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_data  (in_data),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_data (out_data)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Sorts a character into operand, arithmetic operator or rejected operator.
  function automatic sym_class_t classify(input logic [pse_pkg::SYM_W-1:0] sym);
    sym_class_t kind;
    case (sym)
      pse_pkg::CH_PLUS, pse_pkg::CH_MINUS,
      pse_pkg::CH_STAR, pse_pkg::CH_SLASH:                   kind = SYM_ARITH;
      pse_pkg::CH_CARET, pse_pkg::CH_LPAR, pse_pkg::CH_RPAR: kind = SYM_UNSUP;
      default:                                               kind = SYM_OPERAND;
    endcase
    return kind;
  endfunction

  // Applies one character to the shadow stack and returns the report the
  // evaluator must produce for it. An end-of-expression beat empties the stack
  // only after the report has been formed.
  function automatic pse_pkg::out_t apply_symbol(input pse_pkg::in_t beat);
    pse_pkg::out_t report;
    logic [pse_pkg::WORD_W-1:0] lhs;
    logic [pse_pkg::WORD_W-1:0] rhs;
    logic [pse_pkg::WORD_W-1:0] res;
    logic [pse_pkg::WORD_W-1:0] mag_l;
    logic [pse_pkg::WORD_W-1:0] mag_r;
    logic [pse_pkg::WORD_W-1:0] quo;
    logic [pse_pkg::STAT_W-1:0] st;
    st = pse_pkg::ST_OK;
    res = '0;
    case (classify(beat.symbol))
      SYM_UNSUP: begin
        // Rejected before any depth check, so it wins even on an empty stack.
        st = pse_pkg::ST_UNSUP;
      end
      SYM_ARITH: begin
        if (shadow_fill < 2) begin
          st = pse_pkg::ST_UNDER;
        end else begin
          rhs = shadow_stack[shadow_fill - 1];
          lhs = shadow_stack[shadow_fill - 2];
          case (beat.symbol)
            pse_pkg::CH_PLUS:  res = lhs + rhs;
            pse_pkg::CH_MINUS: res = lhs - rhs;
            pse_pkg::CH_STAR:  res = lhs * rhs;
            default: begin
              if (rhs == '0) begin
                st = pse_pkg::ST_DIVZ;
              end else begin
                // Divide magnitudes and fix the sign afterwards: truncates toward
                // zero, and the most negative value over minus one wraps to itself.
                mag_l = lhs[pse_pkg::WORD_W-1] ? (32'd0 - lhs) : lhs;
                mag_r = rhs[pse_pkg::WORD_W-1] ? (32'd0 - rhs) : rhs;
                quo = mag_l / mag_r;
                res = (lhs[pse_pkg::WORD_W-1] ^ rhs[pse_pkg::WORD_W-1]) ? (32'd0 - quo) : quo;
              end
            end
          endcase
          if (st == pse_pkg::ST_OK) begin
            shadow_fill = shadow_fill - 1;
            shadow_stack[shadow_fill - 1] = res;
          end
        end
      end
      default: begin
        if (shadow_fill >= STACK_DEPTH) begin
          st = pse_pkg::ST_OVER;
        end else begin
          // Operand value is the character code minus the code of '0'.
          shadow_stack[shadow_fill] = {24'd0, beat.symbol} - {24'd0, pse_pkg::CH_ZERO};
          shadow_fill = shadow_fill + 1;
        end
      end
    endcase
    report.top_value = (shadow_fill == 0) ? '0 : shadow_stack[shadow_fill - 1];
    report.depth = shadow_fill[pse_pkg::DEPTH_W-1:0];
    report.status = st;
    report.done_res = beat.end_of_expr;
    if (beat.end_of_expr) begin
      shadow_fill = 0;
    end
    return report;
  endfunction

  function automatic logic [pse_pkg::SYM_W-1:0] random_operand();
    logic [pse_pkg::SYM_W-1:0] sym;
    if ($urandom_range(0, 9) < 7) begin
      sym = pse_pkg::CH_ZERO + pse_pkg::SYM_W'($urandom_range(0, 9));
    end else begin
      do begin
        sym = pse_pkg::SYM_W'($urandom_range(0, 255));
      end while (classify(sym) != SYM_OPERAND);
    end
    return sym;
  endfunction

  function automatic logic [pse_pkg::SYM_W-1:0] random_arith();
    logic [pse_pkg::SYM_W-1:0] sym;
    case ($urandom_range(0, 3))
      0:       sym = pse_pkg::CH_PLUS;
      1:       sym = pse_pkg::CH_MINUS;
      2:       sym = pse_pkg::CH_STAR;
      default: sym = pse_pkg::CH_SLASH;
    endcase
    return sym;
  endfunction

  // Presents one character beat and returns at the edge where it is taken.
  // Called at a rising edge; the next beat may be driven in that same step.
  task automatic send_symbol(input logic [pse_pkg::SYM_W-1:0] sym, input logic last);
    pse_pkg::in_t beat;
    beat.symbol = sym;
    beat.end_of_expr = last;
    if (idle_on && $urandom_range(0, 5) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data <= beat;
    do begin
      @(posedge clk);
    end while (!in_ready);
    // The beat is taken at this edge, so the report is predicted now, well
    // ahead of the earliest result the evaluator can return.
    stack_reports_due.push_back(apply_symbol(beat));
    beats_sent++;
  endtask

  // The rejected operators, issued on an empty stack.
  task automatic test_unsupported_symbols();
    send_symbol(pse_pkg::CH_CARET, 1'b0);
    send_symbol(pse_pkg::CH_LPAR, 1'b0);
    send_symbol(pse_pkg::CH_RPAR, 1'b1);
  endtask

  // An operator on an empty stack, then on a stack of one.
  task automatic test_stack_underflow();
    send_symbol(pse_pkg::CH_PLUS, 1'b0);
    send_symbol(pse_pkg::CH_ZERO + 8'd5, 1'b0);
    send_symbol(pse_pkg::CH_SLASH, 1'b1);
  endtask

  // Every operator, a division by zero, and the lowest and highest operand codes.
  // The final 5 / -255 checks that the quotient truncates toward zero.
  task automatic test_arithmetic();
    send_symbol(pse_pkg::CH_ZERO + 8'd5, 1'b0);
    send_symbol(pse_pkg::CH_ZERO + 8'd9, 1'b0);
    send_symbol(pse_pkg::CH_ZERO, 1'b0);
    send_symbol(pse_pkg::CH_SLASH, 1'b0);
    send_symbol(pse_pkg::CH_STAR, 1'b0);
    send_symbol(pse_pkg::CH_PLUS, 1'b0);
    send_symbol(8'h00, 1'b0);
    send_symbol(8'hFF, 1'b0);
    send_symbol(pse_pkg::CH_MINUS, 1'b0);
    send_symbol(pse_pkg::CH_SLASH, 1'b1);
  endtask

  // Builds 2^31 from operands of 128 and 8 (it lands as the most negative word),
  // then divides it by 0 - 1, which has to wrap back to the most negative word.
  task automatic test_quotient_wrap();
    send_symbol(8'd176, 1'b0);
    send_symbol(8'd176, 1'b0);
    send_symbol(pse_pkg::CH_STAR, 1'b0);
    send_symbol(8'd176, 1'b0);
    send_symbol(pse_pkg::CH_STAR, 1'b0);
    send_symbol(8'd176, 1'b0);
    send_symbol(pse_pkg::CH_STAR, 1'b0);
    send_symbol(pse_pkg::CH_ZERO + 8'd8, 1'b0);
    send_symbol(pse_pkg::CH_STAR, 1'b0);
    send_symbol(pse_pkg::CH_ZERO, 1'b0);
    send_symbol(pse_pkg::CH_ZERO + 8'd1, 1'b0);
    send_symbol(pse_pkg::CH_MINUS, 1'b0);
    send_symbol(pse_pkg::CH_SLASH, 1'b1);
  endtask

  // Random expressions until the beat count reaches stop_at. Most are well
  // formed with random operands and operators; some run the stack into
  // overflow, and some are raw bytes with random end marks.
  task automatic test_random_expressions(input int unsigned stop_at);
    int unsigned flavor;
    int unsigned len;
    int unsigned pick;
    logic [pse_pkg::SYM_W-1:0] sym;
    while (beats_sent < stop_at) begin
      flavor = $urandom_range(0, 9);
      if (flavor < 8) begin
        len = $urandom_range(1, 20);
        for (int unsigned i = 0; i < len; i++) begin
          pick = $urandom_range(0, 99);
          if (pick < 3) begin
            case ($urandom_range(0, 2))
              0:       sym = pse_pkg::CH_CARET;
              1:       sym = pse_pkg::CH_LPAR;
              default: sym = pse_pkg::CH_RPAR;
            endcase
          end else if (shadow_fill < 2 || (shadow_fill < STACK_DEPTH - 1 && pick < 55)) begin
            sym = random_operand();
          end else begin
            sym = random_arith();
          end
          send_symbol(sym, i == len - 1);
        end
      end else if (flavor == 8) begin
        // Push operands up to or past the top of the stack, then fold some of it back down.
        len = $urandom_range(STACK_DEPTH - 2, STACK_DEPTH + 4);
        for (int unsigned i = 0; i < len; i++) begin
          send_symbol(random_operand(), 1'b0);
        end
        len = $urandom_range(1, 6);
        for (int unsigned i = 0; i < len; i++) begin
          send_symbol(random_arith(), i == len - 1);
        end
      end else begin
        len = $urandom_range(1, 12);
        for (int unsigned i = 0; i < len; i++) begin
          send_symbol(pse_pkg::SYM_W'($urandom_range(0, 255)), $urandom_range(0, 5) == 0);
        end
      end
    end
  endtask

  // Result-side back-pressure: random stall bursts while idling is on.
  always @(posedge clk) begin
    if (stall_left != 0) begin
      stall_left <= stall_left - 1;
      out_ready <= 1'b0;
    end else if (idle_on && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(0, 13);
      out_ready <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // Compares every accepted result beat with the oldest predicted report.
  always @(posedge clk) begin
    pse_pkg::out_t due;
    if (rst_n && out_valid && out_ready) begin
      if (stack_reports_due.size() == 0) begin
        $error("unexpected result beat: top_value %0d depth %0d status %0d done_res %0b",
               out_data.top_value, out_data.depth, out_data.status, out_data.done_res);
        mismatch_count++;
      end else begin
        due = stack_reports_due.pop_front();
        if (out_data.top_value !== due.top_value) begin
          $error("top_value mismatch: expected %0d, actual %0d",
                 due.top_value, out_data.top_value);
          mismatch_count++;
        end
        if (out_data.depth !== due.depth) begin
          $error("depth mismatch: expected %0d, actual %0d", due.depth, out_data.depth);
          mismatch_count++;
        end
        if (out_data.status !== due.status) begin
          $error("status mismatch: expected %0d, actual %0d", due.status, out_data.status);
          mismatch_count++;
        end
        if (out_data.done_res !== due.done_res) begin
          $error("done_res mismatch: expected %0b, actual %0b",
                 due.done_res, out_data.done_res);
          mismatch_count++;
        end
      end
    end
  end

  // Watchdog on the whole run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("Verification failed");
      $finish;
    end
  end

  initial begin
    repeat (7) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    test_unsupported_symbols();
    test_stack_underflow();
    test_arithmetic();
    test_quotient_wrap();
    test_random_expressions(950);

    // Last stretch runs with both sides always willing, beats back to back.
    idle_on = 1'b0;
    test_random_expressions(1250);
    in_valid <= 1'b0;

    // Drain outstanding reports, then give the evaluator time to emit anything
    // stray; the watchdog bounds the wait.
    while (stack_reports_due.size() != 0) begin
      @(posedge clk);
    end
    repeat (60) @(posedge clk);

    if (mismatch_count == 0) begin
      $display("Verification passed");
    end else begin
      $display("Verification failed");
    end
    $finish;
  end

endmodule
